// ===== rtl/core/dtfx_pkg.sv =====
// Shared types, character codes and tables for the decimal text to fixed-point converter.
// Used by the front parser, the record queue, the back divider and the top level.
// Depends on nothing else.
package dtfx_pkg;

  // Widest fraction accumulator and digit count over the supported parameter range.
  localparam int unsigned FracAccMaxW = 30;
  localparam int unsigned DigitCntW   = 4;

  // Character codes of the accepted number form.
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // Parse phases of the front.
  typedef enum logic [1:0] {
    PhStart,
    PhInt,
    PhFrac,
    PhSkip
  } phase_e;

  // States of the back.
  typedef enum logic [1:0] {
    BackIdle,
    BackDiv,
    BackDone
  } back_state_e;

  // One finished number text, handed from the front to the back.
  typedef struct packed {
    logic                   negative;
    logic [15:0]            int_part;
    logic [FracAccMaxW-1:0] frac_part;
    logic [DigitCntW-1:0]   digit_cnt;
  } num_rec_t;

  // Ten to the power of the fraction digit count.
  function automatic logic [31:0] pow10(input logic [DigitCntW-1:0] n);
    logic [31:0] r;
    case (n)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      4'd9:    r = 32'd1000000000;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/dtfx_front.sv =====
// Front parser: takes one character per transfer and accumulates sign, integer and fraction.
// At the zero byte it pushes a finished record into the queue. Depends on dtfx_pkg.
module dtfx_front import dtfx_pkg::*; #(
  parameter int unsigned MaxFractionDigits = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] character_i,
  output logic       push_o,
  output num_rec_t   push_rec_o,
  input  logic       full_i
);

  localparam int unsigned FracW = $clog2(10 ** MaxFractionDigits);

  phase_e               phase_q, phase_d;
  logic                 neg_q, neg_d;
  logic [15:0]          int_q, int_d;
  logic [FracW-1:0]     frac_q, frac_d;
  logic [DigitCntW-1:0] cnt_q, cnt_d;

  logic       accept;
  logic       is_digit;
  logic [7:0] digit_val;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_digit   = (character_i >= CharZero) && (character_i <= CharNine);
  assign digit_val  = character_i - CharZero;

  // The record leaves on the transfer of the zero byte.
  assign push_o                = accept && (character_i == CharNul);
  assign push_rec_o.negative   = neg_q;
  assign push_rec_o.int_part   = int_q;
  assign push_rec_o.frac_part  = FracAccMaxW'(frac_q);
  assign push_rec_o.digit_cnt  = cnt_q;

  // Phase and accumulator updates for one character.
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    int_d   = int_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    if (accept) begin
      if (character_i == CharNul) begin
        phase_d = PhStart;
        neg_d   = 1'b0;
        int_d   = '0;
        frac_d  = '0;
        cnt_d   = '0;
      end else begin
        case (phase_q)
          PhStart: begin
            if (character_i == CharMinus) begin
              neg_d   = 1'b1;
              phase_d = PhInt;
            end else if (character_i == CharPlus) begin
              phase_d = PhInt;
            end else if (is_digit) begin
              int_d   = (int_q << 3) + (int_q << 1) + {12'd0, digit_val[3:0]};
              phase_d = PhInt;
            end else if (character_i == CharDot) begin
              phase_d = PhFrac;
            end else begin
              phase_d = PhSkip;
            end
          end
          PhInt: begin
            if (is_digit) begin
              int_d = (int_q << 3) + (int_q << 1) + {12'd0, digit_val[3:0]};
            end else if (character_i == CharDot) begin
              phase_d = PhFrac;
            end else begin
              phase_d = PhSkip;
            end
          end
          PhFrac: begin
            if (is_digit && (cnt_q < DigitCntW'(MaxFractionDigits))) begin
              frac_d = (frac_q << 3) + (frac_q << 1) + FracW'(digit_val[3:0]);
              cnt_d  = cnt_q + 1'b1;
            end else begin
              phase_d = PhSkip;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      neg_q   <= 1'b0;
      int_q   <= '0;
      frac_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      int_q   <= int_d;
      frac_q  <= frac_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/dtfx_queue.sv =====
// Two-entry queue of finished number records between the front and the back.
// Depends on dtfx_pkg for the record type.
module dtfx_queue import dtfx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  num_rec_t push_rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output num_rec_t pop_rec_o
);

  num_rec_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign pop_rec_o = mem_q[rd_ptr_q];

  // Record storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/dtfx_back.sv =====
// Back end: divides the scaled fraction by ten to the digit count one quotient bit per
// cycle, adds the shifted integer part, applies the sign and holds the result for transfer.
// Depends on dtfx_pkg.
module dtfx_back import dtfx_pkg::*; #(
  parameter int unsigned MaxFractionDigits = 8,
  parameter int unsigned FractionBits      = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  num_rec_t    pop_rec_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] fixed_value_o
);

  localparam int unsigned FracW = $clog2(10 ** MaxFractionDigits);
  localparam int unsigned StepW = $clog2(FractionBits + 1);

  back_state_e state_q, state_d;

  logic                    neg_q;
  logic [15:0]             int_q;
  logic [FracW-1:0]        rem_q;
  logic [FracW-1:0]        div_q;
  logic [FractionBits-1:0] quo_q;
  logic [StepW-1:0]        step_q;
  logic                    out_valid_q;
  logic [31:0]             out_data_q;

  logic                    load_out;
  logic [FracW:0]          rem_shift;
  logic                    rem_ge;
  logic [FracW:0]          rem_sub;
  logic [47:0]             int_shift;
  logic [31:0]             magnitude;
  logic [31:0]             result;
  logic [31:0]             pow_val;

  assign pow_val   = pow10(pop_rec_i.digit_cnt);
  assign rem_shift = {rem_q, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, div_q};
  assign rem_sub   = rem_shift - {1'b0, div_q};

  // Final assembly of the fixed-point value.
  assign int_shift = {32'd0, int_q} << FractionBits;
  assign magnitude = int_shift[31:0] + 32'(quo_q);
  assign result    = neg_q ? (32'd0 - magnitude) : magnitude;

  assign out_valid_o   = out_valid_q;
  assign fixed_value_o = out_data_q;

  // Sequencer: take a record, run the division, then hand the result over.
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BackIdle: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BackDiv;
        end
      end
      BackDiv: begin
        if (step_q == StepW'(FractionBits - 1)) begin
          state_d = BackDone;
        end
      end
      BackDone: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = BackIdle;
        end
      end
      default: begin
        state_d = BackIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        step_q <= '0;
      end else if (state_q == BackDiv) begin
        step_q <= step_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: the remainder starts as the fraction, which is below the divisor.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      neg_q <= pop_rec_i.negative;
      int_q <= pop_rec_i.int_part;
      rem_q <= pop_rec_i.frac_part[FracW-1:0];
      div_q <= pow_val[FracW-1:0];
      quo_q <= '0;
    end else if (state_q == BackDiv) begin
      if (rem_ge) begin
        rem_q <= rem_sub[FracW-1:0];
      end else begin
        rem_q <= rem_shift[FracW-1:0];
      end
      quo_q <= {quo_q[FractionBits-2:0], rem_ge};
    end
    if (load_out) begin
      out_data_q <= result;
    end
  end

endmodule

// ===== rtl/core/decimal_text_to_fixed_point_top.sv =====
// The input takes one character per cycle while the record queue is not full; the back
// converts one number at a time and pops the next record only after handing over the result.
// The zero byte's transfer pushes the record into the queue; the back pops it, divides, registers the result.
// A two-entry record queue lets the front keep taking characters while the back divides.
// Reset (rst_ni, asynchronous, active low) clears the parser, queue and output valid.
// Depends on dtfx_pkg, dtfx_front, dtfx_queue and dtfx_back.
module decimal_text_to_fixed_point_top import dtfx_pkg::*; #(
  parameter int unsigned MaxFractionDigits = 8,
  parameter int unsigned FractionBits      = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] fixed_value_o
);

  logic     push, full, pop, empty;
  num_rec_t push_rec, pop_rec;

  // Character parser.
  dtfx_front #(
    .MaxFractionDigits(MaxFractionDigits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .character_i(character_i),
    .push_o     (push),
    .push_rec_o (push_rec),
    .full_i     (full)
  );

  // Record queue.
  dtfx_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_rec_i(push_rec),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .pop_rec_o (pop_rec)
  );

  // Divider and output stage.
  dtfx_back #(
    .MaxFractionDigits(MaxFractionDigits),
    .FractionBits     (FractionBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .pop_rec_i    (pop_rec),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .fixed_value_o(fixed_value_o)
  );

endmodule

// ===== bench/decimal_text_to_fixed_point_top_tb.sv =====
// Self-checking testbench for decimal_text_to_fixed_point_top: number texts in, 16.16 values out.
// A scoreboard class predicts each value from the accepted characters; tasks drive the input side.
// Depends on dtfx_pkg and the RTL of decimal_text_to_fixed_point_top.
module decimal_text_to_fixed_point_top_tb;
  import dtfx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxFracDigits = 8;
  localparam int unsigned FracBits      = 16;
  localparam int unsigned CharTarget    = 2000;
  localparam int unsigned DrainCycles   = 4 * (FracBits + 2);
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned ReportLimit   = 10;

  typedef logic [7:0] text_t[$];

  // Tracks the parse of the current text and holds the values still owed by the block.
  class fixed_value_scoreboard;
    phase_e      phase;
    bit          negative;
    logic [15:0] int_acc;
    logic [26:0] frac_acc;
    int unsigned frac_cnt;
    logic [31:0] owed_values[$];
    int unsigned errors;

    function new();
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      phase    = PhStart;
      negative = 1'b0;
      int_acc  = '0;
      frac_acc = '0;
      frac_cnt = 0;
    endfunction

    // Value of the text parsed so far, as the block produces it at the zero byte.
    function logic [31:0] text_value();
      longint unsigned sum;
      longint unsigned divisor;
      logic [31:0]     value;
      divisor = 1;
      for (int unsigned i = 0; i < frac_cnt; i++) divisor = divisor * 10;
      sum   = (longint'(int_acc) << FracBits) + ((longint'(frac_acc) << FracBits) / divisor);
      value = sum[31:0];
      if (negative) value = -value;
      return value;
    endfunction

    // Notes one accepted character transfer.
    function void note_char(logic [7:0] c);
      bit is_num;
      is_num = (c >= CharZero) && (c <= CharNine);
      if (c == CharNul) begin
        owed_values.push_back(text_value());
        clear_text();
        return;
      end
      case (phase)
        PhStart: begin
          if (c == CharMinus) begin
            negative = 1'b1;
            phase    = PhInt;
          end else if (c == CharPlus) begin
            phase = PhInt;
          end else if (is_num) begin
            int_acc = int_acc * 16'd10 + 16'(c - CharZero);
            phase   = PhInt;
          end else if (c == CharDot) begin
            phase = PhFrac;
          end else begin
            phase = PhSkip;
          end
        end
        PhInt: begin
          if (is_num) int_acc = int_acc * 16'd10 + 16'(c - CharZero);
          else if (c == CharDot) phase = PhFrac;
          else phase = PhSkip;
        end
        PhFrac: begin
          if (is_num && frac_cnt < MaxFracDigits) begin
            frac_acc = frac_acc * 27'd10 + 27'(c - CharZero);
            frac_cnt = frac_cnt + 1;
          end else begin
            phase = PhSkip;
          end
        end
        default: ;
      endcase
    endfunction

    // Checks one accepted result transfer against the oldest owed value.
    function void check_value(logic [31:0] actual);
      logic [31:0] owed;
      if (owed_values.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("unexpected fixed_value %0d (0x%08h) with nothing owed",
                   $signed(actual), actual);
        return;
      end
      owed = owed_values.pop_front();
      if (actual !== owed) begin
        errors++;
        if (errors <= ReportLimit)
          $display("fixed_value mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                   $signed(owed), owed, $signed(actual), actual);
      end
    endfunction

    function int unsigned pending();
      return owed_values.size();
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  character_i = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [31:0] fixed_value_o;

  fixed_value_scoreboard sb;
  bit          idle_on = 1'b1;
  int unsigned cycle_count = 0;

  decimal_text_to_fixed_point_top #(
    .MaxFractionDigits(MaxFracDigits),
    .FractionBits     (FracBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .character_i  (character_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .fixed_value_o(fixed_value_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** decimal_text_to_fixed_point_top: FAILED **");
      $finish;
    end
  end

  function automatic text_t from_string(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  // Builds one random text. Most are well formed; some are noise or carry a misplaced symbol.
  // The count covers every byte of the text, the terminating zero byte included.
  function automatic text_t random_text(output int unsigned counted);
    text_t       t;
    int unsigned kind;
    int unsigned n;
    logic [7:0]  stray;
    kind = $urandom_range(0, 9);
    if (kind == 7) begin
      n = $urandom_range(0, 6);
      for (int unsigned i = 0; i < n; i++) t.push_back(8'($urandom_range(1, 255)));
      counted = t.size() + 1;
      return t;
    end
    case ($urandom_range(0, 3))
      0: t.push_back(CharMinus);
      1: t.push_back(CharPlus);
      default: ;
    endcase
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
    for (int unsigned i = 0; i < n; i++) t.push_back(CharZero + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 2) != 0) begin
      t.push_back(CharDot);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(0, MaxFracDigits);
      for (int unsigned i = 0; i < n; i++) t.push_back(CharZero + 8'($urandom_range(0, 9)));
    end
    // Broken form: a sign, a dot or any byte dropped into the text.
    if (kind == 8) begin
      case ($urandom_range(0, 3))
        0: stray = CharMinus;
        1: stray = CharPlus;
        2: stray = CharDot;
        default: stray = 8'($urandom_range(1, 255));
      endcase
      t.insert($urandom_range(0, t.size()), stray);
    end
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 4);
      for (int unsigned i = 0; i < n; i++) t.push_back(8'($urandom_range(1, 255)));
    end
    counted = t.size() + 1;
    return t;
  endfunction

  // Offers one character and waits for its transfer, sometimes idling first.
  task automatic send_char(input logic [7:0] c);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    character_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_char(c);
  endtask

  // Sends a text followed by its terminating zero byte.
  task automatic send_text(input text_t t);
    foreach (t[i]) send_char(t[i]);
    send_char(CharNul);
  endtask

  // Result side: check each transfer and stall in random bursts.
  initial begin
    int unsigned stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_value(fixed_value_o);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall = $urandom_range(0, 6);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed texts, random texts, drain.
  initial begin
    text_t       t;
    int unsigned sent;
    int unsigned counted;
    int unsigned next_chunk;
    bit          paused;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty text, sign only, the most negative value, integer wrap with too many
    // fraction digits, a sign after the first character, a noise byte first, a bare fraction.
    send_text(from_string(""));
    send_text(from_string("-"));
    send_text(from_string("-32768"));
    send_text(from_string("99999.123456789"));
    send_text(from_string("1-2"));
    t = from_string(".5");
    t.push_front(8'hFF);
    send_text(t);
    send_text(from_string("+.5"));

    // Random texts, in chunks that idle or not; no idling over the last part.
    sent       = 0;
    next_chunk = 0;
    paused     = 1'b0;
    while (sent < CharTarget) begin
      if (sent >= next_chunk) begin
        idle_on    = (sent < CharTarget * 85 / 100) && ($urandom_range(0, 3) != 0);
        next_chunk = sent + 150;
      end
      // Hold the sender once until the block has delivered everything owed.
      if (!paused && sent >= CharTarget / 2) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      t = random_text(counted);
      send_text(t);
      sent += counted;
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** decimal_text_to_fixed_point_top: PASSED **");
    end else begin
      $display("** decimal_text_to_fixed_point_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dtfx_pkg.sv
rtl/core/dtfx_front.sv
rtl/core/dtfx_queue.sv
rtl/core/dtfx_back.sv
rtl/core/decimal_text_to_fixed_point_top.sv
bench/decimal_text_to_fixed_point_top_tb.sv
